/* rtl/lfrf_pkg.sv */
// Package for the length-framed record FIFO: operation and status codes,
// sequencer states, field widths and default depths.
// No dependencies.
package lfrf_pkg;

    localparam int STORE_DEPTH_DEF  = 4096;
    localparam int RECORD_DEPTH_DEF = 256;

    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int STAT_W   = 2;
    localparam int HEAD_W   = 13;
    localparam int COUNT_W  = 9;
    localparam int USED_W   = 13;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_DISCARD = 3'd2,
        OP_QUERY   = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_OVF   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LEN,
        ST_DONE
    } t_state;

endpackage

/* rtl/length_framed_record_fifo_unit.sv */
// Length-framed record FIFO: byte store and length queue held in two
// synchronous memories, with a small sequencer around them.
// Depends on lfrf_pkg.
//
// Usage
//   Slave channel: one command word per handshake. tuser carries the
//   operation (push, pop, discard head record, query, clear), tdata the
//   byte to push and tlast the end-of-record mark for a push.
//   Master channel: exactly one result word per command. tdata carries the
//   popped byte, the remaining head length, the record count and the bytes
//   held; tuser the status (ok, empty, overflow); tlast marks the final
//   byte of a record on pop.
//   Timing: a command is accepted only while the sequencer is idle, so a
//   new command waits until the last one has loaded the result register.
//   Steps: the registered read of both memories, the update, then the
//   load of the result register, held off while it holds an untaken word;
//   a pop or discard retiring the head record reads the new head length in that last step.
//   Reset: pointers, counters and the output valid flag are cleared; memory
//   contents are kept and are only ever read for committed records.
//   Stall: the result register holds until taken; one further command may
//   be accepted and processed meanwhile, its result waiting behind it.
module length_framed_record_fifo_unit
    import lfrf_pkg::*;
#(
    parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
    parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [BYTE_W-1:0]     i_s_tdata,   // [7:0] data_in
    input  logic [OP_W-1:0]       i_s_tuser,   // [2:0] operation
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [7:0] data_out, [20:8] head_length, [29:21] record_count,
    // [42:30] bytes_used, [47:43] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [STAT_W-1:0]     o_m_tuser,   // [1:0] status
    output logic                  o_m_tlast
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int CW   = $clog2(STORE_DEPTH + 1);
    localparam int CW1  = CW + 1;
    localparam int RAW  = $clog2(RECORD_DEPTH);
    localparam int RCW  = $clog2(RECORD_DEPTH + 1);
    localparam int PADW = OUT_DATA_W - BYTE_W - HEAD_W - COUNT_W - USED_W;

    localparam logic [AW-1:0]  BPTR_LAST = AW'(STORE_DEPTH - 1);
    localparam logic [RAW-1:0] LPTR_LAST = RAW'(RECORD_DEPTH - 1);
    localparam logic [CW-1:0]  SD_C      = CW'(STORE_DEPTH);
    localparam logic [CW1-1:0] SD_W      = CW1'(STORE_DEPTH);
    localparam logic [RCW-1:0] RD_C      = RCW'(RECORD_DEPTH);

    logic [BYTE_W-1:0] r_byte_mem [STORE_DEPTH];
    logic [CW-1:0]     r_len_mem  [RECORD_DEPTH];
    logic [BYTE_W-1:0] r_byte_rd;
    logic [CW-1:0]     r_len_rd;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op;
    logic [BYTE_W-1:0] r_din;
    logic              r_last;

    logic [AW-1:0]     r_bwp, n_bwp, r_brp, n_brp;
    logic [RAW-1:0]    r_lwp, n_lwp, r_lrp, n_lrp;
    logic [CW-1:0]     r_used, n_used, r_open, n_open, r_hr, n_hr;
    logic [RCW-1:0]    r_cnt, n_cnt;
    logic              r_drop, n_drop;

    logic [BYTE_W-1:0] r_res_data, n_res_data;
    logic              r_res_last, n_res_last;
    t_status           r_res_stat, n_res_stat;
    logic [CW-1:0]     r_res_head, n_res_head;

    logic              r_ov, n_ov;
    logic [BYTE_W-1:0] r_m_data, n_m_data;
    logic              r_m_last, n_m_last;
    t_status           r_m_stat, n_m_stat;
    logic [HEAD_W-1:0] r_m_head, n_m_head;
    logic [COUNT_W-1:0] r_m_cnt, n_m_cnt;
    logic [USED_W-1:0] r_m_used, n_m_used;

    logic              w_bwe, w_lwe, w_accept, w_slot;
    logic [CW-1:0]     w_head, w_open_inc;
    logic [CW1-1:0]    w_rew, w_skip;
    logic [AW-1:0]     w_bwp_inc, w_brp_inc;
    logic [RAW-1:0]    w_lwp_inc, w_lrp_inc;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_slot     = !r_ov || i_m_tready;

    assign w_head     = (r_cnt == '0) ? '0 : ((r_hr != '0) ? r_hr : r_len_rd);
    assign w_open_inc = r_open + 1'b1;
    assign w_rew      = CW1'(r_bwp) + SD_W - CW1'(r_open);
    assign w_skip     = CW1'(r_brp) + CW1'(w_head);
    assign w_bwp_inc  = (r_bwp == BPTR_LAST) ? '0 : r_bwp + 1'b1;
    assign w_brp_inc  = (r_brp == BPTR_LAST) ? '0 : r_brp + 1'b1;
    assign w_lwp_inc  = (r_lwp == LPTR_LAST) ? '0 : r_lwp + 1'b1;
    assign w_lrp_inc  = (r_lrp == LPTR_LAST) ? '0 : r_lrp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_bwe) begin
            r_byte_mem[r_bwp] <= r_din;
        end
        r_byte_rd <= r_byte_mem[r_brp];
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) begin
            r_len_mem[r_lwp] <= w_open_inc;
        end
        r_len_rd <= r_len_mem[n_lrp];
    end

    always_comb begin
        n_state    = r_state;
        n_bwp      = r_bwp;
        n_brp      = r_brp;
        n_lwp      = r_lwp;
        n_lrp      = r_lrp;
        n_used     = r_used;
        n_open     = r_open;
        n_hr       = r_hr;
        n_cnt      = r_cnt;
        n_drop     = r_drop;
        n_res_data = r_res_data;
        n_res_last = r_res_last;
        n_res_stat = r_res_stat;
        n_res_head = r_res_head;
        n_ov       = r_ov && !i_m_tready;
        n_m_data   = r_m_data;
        n_m_last   = r_m_last;
        n_m_stat   = r_m_stat;
        n_m_head   = r_m_head;
        n_m_cnt    = r_m_cnt;
        n_m_used   = r_m_used;
        w_bwe      = 1'b0;
        w_lwe      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state    = ST_DONE;
                n_res_data = '0;
                n_res_last = 1'b0;
                n_res_stat = STAT_OK;
                n_res_head = w_head;
                unique case (r_op)
                    OP_PUSH: begin
                        if (r_drop) begin
                            n_res_stat = STAT_OVF;
                            if (r_last) begin
                                n_drop = 1'b0;
                            end
                        end else if (r_used >= SD_C || (r_last && r_cnt >= RD_C)) begin
                            // drop the open record
                            n_bwp      = (w_rew >= SD_W) ? AW'(w_rew - SD_W) : AW'(w_rew);
                            n_used     = (r_used >= r_open) ? r_used - r_open : '0;
                            n_open     = '0;
                            n_drop     = !r_last;
                            n_res_stat = STAT_OVF;
                        end else begin
                            w_bwe  = 1'b1;
                            n_bwp  = w_bwp_inc;
                            n_used = r_used + 1'b1;
                            n_open = w_open_inc;
                            if (r_last) begin
                                w_lwe  = 1'b1;
                                n_lwp  = w_lwp_inc;
                                n_cnt  = r_cnt + 1'b1;
                                n_open = '0;
                                if (r_cnt == '0) begin
                                    n_res_head = w_open_inc;
                                end
                            end
                        end
                    end
                    OP_POP: begin
                        if (r_cnt == '0) begin
                            n_res_stat = STAT_EMPTY;
                        end else begin
                            n_res_data = r_byte_rd;
                            n_brp      = w_brp_inc;
                            if (r_used != '0) begin
                                n_used = r_used - 1'b1;
                            end
                            if (w_head <= CW'(1)) begin
                                n_res_last = 1'b1;
                                n_lrp      = w_lrp_inc;
                                n_cnt      = r_cnt - 1'b1;
                                n_hr       = '0;
                                n_state    = ST_LEN;
                            end else begin
                                n_hr       = w_head - 1'b1;
                                n_res_head = w_head - 1'b1;
                            end
                        end
                    end
                    OP_DISCARD: begin
                        if (r_cnt == '0) begin
                            n_res_stat = STAT_EMPTY;
                        end else begin
                            n_brp   = (w_skip >= SD_W) ? AW'(w_skip - SD_W) : AW'(w_skip);
                            n_used  = (r_used >= w_head) ? r_used - w_head : '0;
                            n_lrp   = w_lrp_inc;
                            n_cnt   = r_cnt - 1'b1;
                            n_hr    = '0;
                            n_state = ST_LEN;
                        end
                    end
                    OP_CLEAR: begin
                        n_bwp      = '0;
                        n_brp      = '0;
                        n_lwp      = '0;
                        n_lrp      = '0;
                        n_used     = '0;
                        n_open     = '0;
                        n_hr       = '0;
                        n_cnt      = '0;
                        n_drop     = 1'b0;
                        n_res_head = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_LEN, ST_DONE: begin
                if (w_slot) begin
                    n_state  = ST_IDLE;
                    n_ov     = 1'b1;
                    n_m_data = r_res_data;
                    n_m_last = r_res_last;
                    n_m_stat = r_res_stat;
                    n_m_cnt  = COUNT_W'(r_cnt);
                    n_m_used = USED_W'(r_used);
                    if (r_state == ST_LEN) begin
                        // head record retired: the new head comes from the length queue
                        n_m_head = (r_cnt == '0) ? '0 : HEAD_W'(r_len_rd);
                    end else begin
                        n_m_head = HEAD_W'(r_res_head);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bwp   <= '0;
            r_brp   <= '0;
            r_lwp   <= '0;
            r_lrp   <= '0;
            r_used  <= '0;
            r_open  <= '0;
            r_hr    <= '0;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bwp   <= n_bwp;
            r_brp   <= n_brp;
            r_lwp   <= n_lwp;
            r_lrp   <= n_lrp;
            r_used  <= n_used;
            r_open  <= n_open;
            r_hr    <= n_hr;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_s_tuser;
            r_din  <= i_s_tdata;
            r_last <= i_s_tlast;
        end
        r_res_data <= n_res_data;
        r_res_last <= n_res_last;
        r_res_stat <= n_res_stat;
        r_res_head <= n_res_head;
        r_m_data   <= n_m_data;
        r_m_last   <= n_m_last;
        r_m_stat   <= n_m_stat;
        r_m_head   <= n_m_head;
        r_m_cnt    <= n_m_cnt;
        r_m_used   <= n_m_used;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{PADW{1'b0}}, r_m_used, r_m_cnt, r_m_head, r_m_data};
    assign o_m_tuser  = r_m_stat;
    assign o_m_tlast  = r_m_last;

endmodule
